FILE: rtl/length_prefixed_frame_deframer_assert.svh
// Assertion macros used by the deframer top module.
`ifndef LENGTH_PREFIXED_FRAME_DEFRAMER_ASSERT_SVH
`define LENGTH_PREFIXED_FRAME_DEFRAMER_ASSERT_SVH

// Same-cycle implication.
`define LPFD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define LPFD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/lpfd_pkg.sv
package lpfd_pkg;

  localparam logic [7:0] BYTE_SYNC = 8'hFF;

  localparam logic KIND_DATA    = 1'b0;
  localparam logic KIND_RESTART = 1'b1;

  typedef struct packed {
    logic       done;
    logic       last;
    logic [7:0] data;
    logic       pvalid;
    logic       consumed;
  } lpfd_result_t;

endpackage

FILE: rtl/length_prefixed_frame_deframer.sv
// Length-prefixed frame deframer, one byte per beat.
// Input stream: s_axis_tdata carries the byte, s_axis_tuser set means restart
// (clear the parser; the byte is ignored). Output stream: one beat per input
// beat, with the payload byte in m_axis_tdata (zero when not payload),
// m_axis_tlast on the final payload byte, and consumed, payload valid and
// message done flags in m_axis_tuser.
// With seek_magic set the parser waits for four 0xFF bytes, then reads a
// 4-byte little-endian length and passes that many payload bytes. Once done,
// bytes come back as not consumed until a restart beat.
// Path: an accepted beat is written into a queue entry and from there into the
// output register. Throughput: one beat per cycle while the queue is not full,
// set by the parser state update and 32-bit count compare in the front stage.
// Reset: parser idle, seek_magic = 1, queue and output register empty.
// Receiver stall: results collect in the QUEUE_DEPTH-entry queue and the
// output register; s_axis_tready drops only when the queue is full.
module length_prefixed_frame_deframer
  import lpfd_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,     // seek_magic
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,    // [7:0] byte_value
  input  logic       s_axis_tuser,    // [0] kind
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,    // [7:0] payload_byte
  output logic       m_axis_tlast,
  output logic [2:0] m_axis_tuser     // [0] consumed, [1] payload_valid, [2] message_done
);

  `include "length_prefixed_frame_deframer_assert.svh"

  logic         push;
  logic         q_full;
  logic         pop;
  logic         q_not_empty;
  lpfd_result_t push_data;
  lpfd_result_t q_data;
  lpfd_result_t out_data;

  lpfd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .in_kind     (s_axis_tuser),
    .in_byte     (s_axis_tdata),
    .q_full      (q_full),
    .push        (push),
    .push_data   (push_data)
  );

  lpfd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .not_empty (q_not_empty),
    .pop_data  (q_data)
  );

  lpfd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .q_data      (q_data),
    .pop         (pop),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_data    (out_data)
  );

  assign m_axis_tdata = out_data.data;
  assign m_axis_tlast = out_data.last;
  assign m_axis_tuser = {out_data.done, out_data.pvalid, out_data.consumed};

  `LPFD_ASSERT_NOW(a_last_ends_msg, clk, rst, m_axis_tvalid && m_axis_tlast, m_axis_tuser[1] && m_axis_tuser[2], "last beat without payload or done")
  `LPFD_ASSERT_NOW(a_idle_byte_zero, clk, rst, m_axis_tvalid && !m_axis_tuser[1], m_axis_tdata == 8'd0 && !m_axis_tlast, "non-payload beat carries data")
  `LPFD_ASSERT_NOW(a_restart_clean, clk, rst, push && s_axis_tuser == KIND_RESTART, push_data == '0, "restart result not all zero")
  `LPFD_ASSERT_NEXT(a_pop_fills_out, clk, rst, pop, m_axis_tvalid, "popped result lost")

endmodule

FILE: rtl/lpfd_front.sv
module lpfd_front
  import lpfd_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_wr_en,
  input  logic         cfg_wr_data,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic         in_kind,
  input  logic [7:0]   in_byte,
  input  logic         q_full,
  output logic         push,
  output lpfd_result_t push_data
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SYNC1,
    S_SYNC2,
    S_SYNC3,
    S_SYNC4,
    S_LEN1,
    S_LEN2,
    S_LEN3,
    S_BODY,
    S_DONE
  } state_t;

  state_t      state;
  state_t      state_next;
  logic [31:0] length;
  logic [31:0] length_next;
  logic [31:0] count;
  logic [31:0] count_next;
  logic        seek_magic;
  logic        is_sync;

  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;
  assign is_sync  = (in_byte == BYTE_SYNC);

  always_comb begin
    state_next  = state;
    length_next = length;
    count_next  = count;
    push_data   = '0;
    if (in_kind == KIND_RESTART) begin
      state_next  = S_IDLE;
      length_next = '0;
      count_next  = '0;
    end else begin
      unique case (state)
        S_SYNC1: begin
          push_data.consumed = 1'b1;
          state_next = is_sync ? S_SYNC2 : S_IDLE;
        end
        S_SYNC2: begin
          push_data.consumed = 1'b1;
          state_next = is_sync ? S_SYNC3 : S_IDLE;
        end
        S_SYNC3: begin
          push_data.consumed = 1'b1;
          state_next = is_sync ? S_SYNC4 : S_IDLE;
        end
        S_SYNC4: begin
          push_data.consumed = 1'b1;
          length_next = {24'd0, in_byte};
          state_next  = S_LEN1;
        end
        S_LEN1: begin
          push_data.consumed = 1'b1;
          length_next = {length[31:16], in_byte, length[7:0]};
          state_next  = S_LEN2;
        end
        S_LEN2: begin
          push_data.consumed = 1'b1;
          length_next = {length[31:24], in_byte, length[15:0]};
          state_next  = S_LEN3;
        end
        S_LEN3: begin
          push_data.consumed = 1'b1;
          length_next = {in_byte, length[23:0]};
          count_next  = '0;
          state_next  = (length_next == 32'd0) ? S_DONE : S_BODY;
        end
        S_BODY: begin
          push_data.consumed = 1'b1;
          push_data.pvalid   = 1'b1;
          push_data.data     = in_byte;
          count_next         = count + 32'd1;
          if (count_next == length) begin
            push_data.last = 1'b1;
            state_next     = S_DONE;
          end
        end
        S_DONE: begin
        end
        default: begin
          push_data.consumed = 1'b1;
          if (seek_magic) begin
            state_next = is_sync ? S_SYNC1 : S_IDLE;
          end else begin
            length_next = {24'd0, in_byte};
            state_next  = S_LEN1;
          end
        end
      endcase
    end
    push_data.done = (state_next == S_DONE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      length     <= '0;
      count      <= '0;
      seek_magic <= 1'b1;
    end else begin
      if (push) begin
        state  <= state_next;
        length <= length_next;
        count  <= count_next;
      end
      if (cfg_wr_en) begin
        seek_magic <= cfg_wr_data;
      end
    end
  end

endmodule

FILE: rtl/lpfd_queue.sv
module lpfd_queue
  import lpfd_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  lpfd_result_t push_data,
  output logic         full,
  input  logic         pop,
  output logic         not_empty,
  output lpfd_result_t pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  lpfd_result_t entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign pop_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

FILE: rtl/lpfd_back.sv
module lpfd_back
  import lpfd_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         q_not_empty,
  input  lpfd_result_t q_data,
  output logic         pop,
  output logic         out_valid,
  input  logic         out_ready,
  output lpfd_result_t out_data
);

  assign pop = q_not_empty && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data <= q_data;
    end
  end

endmodule

FILE: dv/lpfd_frame_checker.sv
module lpfd_frame_checker
  import lpfd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,
  input  logic       s_axis_tvalid,
  input  logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,
  input  logic       s_axis_tuser,
  input  logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  input  logic [7:0] m_axis_tdata,
  input  logic       m_axis_tlast,
  input  logic [2:0] m_axis_tuser,
  output int         mismatches,
  output int         pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [3:0] {
    PS_IDLE,
    PS_SYNC1,
    PS_SYNC2,
    PS_SYNC3,
    PS_SYNC4,
    PS_LEN1,
    PS_LEN2,
    PS_LEN3,
    PS_BODY,
    PS_DONE
  } parse_state_t;

  logic         seek_magic;
  parse_state_t state;
  logic [31:0]  frame_len;
  logic [31:0]  body_count;
  lpfd_result_t expected_beats[$];

  function automatic void clear_parser();
    state = PS_IDLE;
    frame_len = '0;
    body_count = '0;
  endfunction

  function automatic lpfd_result_t parse_byte(input logic kind, input logic [7:0] b);
    lpfd_result_t r;
    r = '0;
    if (kind == KIND_RESTART) begin
      clear_parser();
    end else begin
      unique case (state)
        PS_SYNC1, PS_SYNC2, PS_SYNC3: begin
          r.consumed = 1'b1;
          state = (b == BYTE_SYNC) ? parse_state_t'(state + 4'd1) : PS_IDLE;
        end
        PS_SYNC4: begin
          r.consumed = 1'b1;
          frame_len = {24'd0, b};
          state = PS_LEN1;
        end
        PS_LEN1: begin
          r.consumed = 1'b1;
          frame_len[15:8] = b;
          state = PS_LEN2;
        end
        PS_LEN2: begin
          r.consumed = 1'b1;
          frame_len[23:16] = b;
          state = PS_LEN3;
        end
        PS_LEN3: begin
          r.consumed = 1'b1;
          frame_len[31:24] = b;
          body_count = '0;
          state = (frame_len == 32'd0) ? PS_DONE : PS_BODY;
        end
        PS_BODY: begin
          r.consumed = 1'b1;
          r.pvalid = 1'b1;
          r.data = b;
          body_count = body_count + 32'd1;
          if (body_count == frame_len) begin
            r.last = 1'b1;
            state = PS_DONE;
          end
        end
        PS_DONE: begin
        end
        default: begin
          r.consumed = 1'b1;
          if (seek_magic) begin
            state = (b == BYTE_SYNC) ? PS_SYNC1 : PS_IDLE;
          end else begin
            frame_len = {24'd0, b};
            state = PS_LEN1;
          end
        end
      endcase
    end
    r.done = (state == PS_DONE);
    return r;
  endfunction

  function automatic void compare_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  task automatic check_beat();
    lpfd_result_t want;
    if (expected_beats.size() == 0) begin
      $error("output beat with nothing expected: tdata %0h tlast %b tuser %b",
             m_axis_tdata, m_axis_tlast, m_axis_tuser);
      mismatches++;
    end else begin
      want = expected_beats.pop_front();
      compare_field("consumed", 8'(want.consumed), 8'(m_axis_tuser[0]));
      compare_field("payload_valid", 8'(want.pvalid), 8'(m_axis_tuser[1]));
      compare_field("payload_byte", want.data, m_axis_tdata);
      compare_field("payload_last", 8'(want.last), 8'(m_axis_tlast));
      compare_field("message_done", 8'(want.done), 8'(m_axis_tuser[2]));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      seek_magic = 1'b1;
      clear_parser();
      expected_beats.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        check_beat();
      end
      if (s_axis_tvalid && s_axis_tready) begin
        expected_beats.push_back(parse_byte(s_axis_tuser, s_axis_tdata));
      end
      if (cfg_wr_en) begin
        seek_magic = cfg_wr_data;
      end
    end
    pending = expected_beats.size();
  end

endmodule

FILE: dv/tb_length_prefixed_frame_deframer.sv
module tb_length_prefixed_frame_deframer;
  import lpfd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int BEAT_TARGET = 1400;
  localparam int PHASES      = 4;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 120;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_wr_en = 1'b0;
  logic       cfg_wr_data = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = 8'd0;
  logic       s_axis_tuser = KIND_DATA;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;
  logic       m_axis_tlast;
  logic [2:0] m_axis_tuser;

  int mismatches;
  int pending;
  int beats_sent = 0;
  int cycle_count = 0;
  bit src_gaps = 1'b0;
  bit dst_gaps = 1'b0;
  bit hold_req = 1'b0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  length_prefixed_frame_deframer dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  lpfd_frame_checker u_checker (.*);

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_length_prefixed_frame_deframer: done, errors");
      $finish;
    end
  end

  // receiver: random stalls, plus one long hold on request
  initial begin
    wait (!rst);
    @(negedge clk);
    forever begin
      if (hold_req) begin
        m_axis_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else if (dst_gaps && $urandom_range(0, 7) == 0) begin
        m_axis_tready = 1'b0;
        repeat ($urandom_range(1, 17)) @(negedge clk);
      end else begin
        m_axis_tready = 1'b1;
        @(negedge clk);
      end
    end
  end

  task automatic send_beat(input logic kind, input logic [7:0] b);
    if (src_gaps && $urandom_range(0, 7) == 0) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser = kind;
    s_axis_tdata = b;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    beats_sent++;
  endtask

  task automatic send_data(input logic [7:0] b);
    send_beat(KIND_DATA, b);
  endtask

  task automatic send_restart();
    send_beat(KIND_RESTART, 8'($urandom));
  endtask

  task automatic send_sync();
    repeat (4) send_data(BYTE_SYNC);
  endtask

  task automatic send_length(input logic [31:0] n);
    for (int i = 0; i < 4; i++) begin
      send_data(n[8*i +: 8]);
    end
  endtask

  task automatic wait_idle();
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_seek(input logic v);
    cfg_wr_data = v;
    cfg_wr_en = 1'b1;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  // mostly well-formed frames with random content, some noise and broken sync
  task automatic send_frame(input bit seek);
    int unsigned pick;
    int unsigned len_pick;
    logic [31:0] len;
    int unsigned body;
    pick = $urandom_range(0, 19);
    if (pick < 2) begin
      repeat ($urandom_range(1, 12)) begin
        if ($urandom_range(0, 9) == 0) begin
          send_restart();
        end else begin
          send_data($urandom_range(0, 1) ? BYTE_SYNC : 8'($urandom));
        end
      end
      send_restart();
      return;
    end
    if (seek) begin
      if (pick < 5) begin
        repeat ($urandom_range(1, 3)) send_data(BYTE_SYNC);
        send_data(8'($urandom_range(0, 254)));
      end
      send_sync();
    end
    len_pick = $urandom_range(0, 19);
    if (len_pick == 0) begin
      len = 32'd0;
    end else if (len_pick < 3) begin
      len = $urandom;
    end else begin
      len = $urandom_range(1, 8);
    end
    send_length(len);
    body = (len > 32'd12) ? $urandom_range(0, 12) : len;
    repeat (body) send_data(8'($urandom));
    if (body == len) begin
      repeat ($urandom_range(0, 2)) send_data(8'($urandom));
    end
    send_restart();
  endtask

  initial begin
    bit seek_on;
    int phase_end;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    src_gaps = 1'b1;
    dst_gaps = 1'b1;

    send_data(8'h00);
    send_data(BYTE_SYNC);
    send_data(8'h00);
    send_data(BYTE_SYNC);
    send_data(BYTE_SYNC);
    send_data(8'h7E);
    send_sync();
    send_length(32'd2);
    send_data(8'h00);
    send_data(8'hFF);
    send_data(8'h55);
    send_restart();
    send_sync();
    send_length(32'd0);
    send_data(8'hAA);
    send_restart();
    wait_idle();

    // fill the output queue while the receiver holds off
    src_gaps = 1'b0;
    hold_req = 1'b1;
    send_sync();
    send_length(32'd20);
    repeat (20) send_data(8'($urandom));
    send_restart();
    src_gaps = 1'b1;
    wait_idle();

    write_seek(1'b0);
    send_length(32'd3);
    send_data(8'hFF);
    send_data(8'h00);
    send_data(8'h81);
    send_data(8'h3C);
    send_restart();
    send_length(32'hFFFF_FFFF);
    send_data(8'h01);
    send_data(8'hFE);
    send_restart();
    send_length(32'd0);
    send_data(8'h01);
    send_restart();
    wait_idle();

    for (int p = 0; p < PHASES; p++) begin
      seek_on = (p % 2 == 0);
      write_seek(seek_on);
      if (p == PHASES - 1) begin
        src_gaps = 1'b0;
        dst_gaps = 1'b0;
      end
      phase_end = beats_sent + BEAT_TARGET / PHASES;
      while (beats_sent < phase_end) send_frame(seek_on);
      wait_idle();
    end

    repeat (10) @(negedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("tb_length_prefixed_frame_deframer: done, clean");
    end else begin
      $display("tb_length_prefixed_frame_deframer: done, errors");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/lpfd_pkg.sv
rtl/lpfd_front.sv
rtl/lpfd_queue.sv
rtl/lpfd_back.sv
rtl/length_prefixed_frame_deframer.sv
dv/lpfd_frame_checker.sv
dv/tb_length_prefixed_frame_deframer.sv
